FILE: design/i2c_auth_responder_core_defines.svh
// Assertion macros shared by the block.
`ifndef I2C_AUTH_RESPONDER_CORE_DEFINES_SVH
`define I2C_AUTH_RESPONDER_CORE_DEFINES_SVH
// An implication that is checked whenever reset is released.
`define IAR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// An implication whose consequent is checked in the cycle after its antecedent.
`define IAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: design/iar_pkg.sv
`timescale 1ns / 1ps
package iar_pkg;
  localparam int CmdBufferBytes = 32;
  localparam int BufAw = $clog2(CmdBufferBytes);
  localparam int RespBytes = 16;

  localparam logic [2:0] CMD_START_WRITE = 3'd0;
  localparam logic [2:0] CMD_START_READ  = 3'd1;
  localparam logic [2:0] CMD_FINISH      = 3'd2;
  localparam logic [2:0] CMD_WRITE_BYTE  = 3'd4;
  localparam logic [2:0] CMD_READ_BYTE   = 3'd5;

  localparam logic [7:0] REG_NONCE   = 8'h30;
  localparam logic [7:0] REG_ROUND0  = 8'he9;
  localparam logic [7:0] REG_ROUND1  = 8'h87;
  localparam logic [7:0] REG_PHASE3  = 8'h40;
  localparam logic [7:0] REG_ZERO_LO = 8'h73;
  localparam logic [7:0] REG_ZERO_HI = 8'h76;

  localparam logic [63:0] KEY0 = 64'h9fb7fb2cc0360a1e;
  localparam logic [63:0] KEY1 = 64'h09216dba56a09c88;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_CIPHER, ST_SPREAD, ST_OUT
  } state_t;

  typedef struct packed {
    logic exec;
    logic cipher_start;
    logic spread;
  } cmd_t;

  typedef struct packed {
    logic need_cipher;
    logic cipher_done;
  } status_t;
endpackage

FILE: design/iar_datapath.sv
`timescale 1ns / 1ps
`include "i2c_auth_responder_core_defines.svh"
module iar_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        in_command,
  input  logic [7:0]        in_data_byte,
  input  iar_pkg::cmd_t     cmd,
  output iar_pkg::status_t  sts,
  output logic [7:0]        result
);
  logic reading_r;
  logic [5:0] wcount_r;
  logic [7:0] wbuf [iar_pkg::CmdBufferBytes];
  logic [7:0] ptr_r;
  logic [7:0] resp_r [iar_pkg::RespBytes];
  logic [4:0] rlen_r, rpos_r;
  logic [7:0] cnt_r;
  logic p0_r, p1_r;
  logic [63:0] t0_r, t1_r;
  logic [7:0] result_r;

  // Cipher sequencer: keys run backwards from the last right rotation.
  logic [63:0] v_r, s_r;
  logic [5:0] step_r;
  logic rnd_r, busy_r;

  logic [63:0] gathered;
  always_comb begin
    gathered = '0;
    for (int i = 0; i < 8; i++) gathered = {gathered[55:0], wbuf[1 + 2 * i]};
  end

  logic is_round;
  assign is_round = (ptr_r == iar_pkg::REG_ROUND0 && p0_r) ||
                    (ptr_r == iar_pkg::REG_ROUND1 && p1_r);
  assign sts.need_cipher = (in_command == iar_pkg::CMD_START_READ) && is_round;
  assign sts.cipher_done = busy_r && (step_r == 6'd0) && rnd_r == 1'b0;

  // s at right step j (1..31) is key rotated left by 3*(31-j) bits total.
  function automatic logic [63:0] key_at(input logic r, input logic [7:0] c);
    key_at = (r ? iar_pkg::KEY1 : iar_pkg::KEY0) ^ ({56'd0, c} << 32);
  endfunction

  logic [63:0] s_cur;
  logic [7:0] tb;
  logic [2:0] sel;
  assign s_cur = s_r;
  assign tb = s_cur[63:56];
  assign sel = {tb[5], tb[7:6]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reading_r <= 1'b0; wcount_r <= '0; rlen_r <= '0; rpos_r <= '0;
      cnt_r <= '0; p0_r <= 1'b0; p1_r <= 1'b0; busy_r <= 1'b0;
      ptr_r <= '0; result_r <= '0;
    end else begin
      if (cmd.exec) begin
        unique case (in_command)
          iar_pkg::CMD_START_WRITE: begin
            reading_r <= 1'b0; wcount_r <= '0; result_r <= '0;
          end
          iar_pkg::CMD_START_READ: begin
            reading_r <= 1'b1; rpos_r <= '0; rlen_r <= 5'd16; result_r <= '0;
            for (int i = 0; i < iar_pkg::RespBytes; i++) resp_r[i] <= '0;
            if (ptr_r == iar_pkg::REG_NONCE) begin
              cnt_r <= 8'd1; p0_r <= 1'b0; p1_r <= 1'b0;
            end else if (ptr_r >= iar_pkg::REG_ZERO_LO &&
                         ptr_r <= iar_pkg::REG_ZERO_HI) begin
              rlen_r <= 5'd8;
            end else if (ptr_r == iar_pkg::REG_ROUND0 && p0_r) begin
              cnt_r <= cnt_r + 8'd1; p0_r <= 1'b0; v_r <= t0_r;
            end else if (ptr_r == iar_pkg::REG_ROUND1 && p1_r) begin
              cnt_r <= cnt_r + 8'd1; p1_r <= 1'b0; v_r <= t1_r;
            end
          end
          iar_pkg::CMD_FINISH: begin
            result_r <= '0;
            if (!reading_r && wcount_r > 6'd1) begin
              if (ptr_r == iar_pkg::REG_PHASE3) cnt_r <= cnt_r + 8'd2;
              else if (ptr_r == iar_pkg::REG_ROUND0 && wcount_r >= 6'd16) begin
                t0_r <= gathered; p0_r <= 1'b1;
              end else if (ptr_r == iar_pkg::REG_ROUND1 && wcount_r >= 6'd16) begin
                t1_r <= gathered; p1_r <= 1'b1;
              end
            end
          end
          iar_pkg::CMD_WRITE_BYTE: begin
            result_r <= '0;
            if (wcount_r < 6'd63) begin
              if ({2'b0, wcount_r} < 8'(iar_pkg::CmdBufferBytes)) begin
                wbuf[wcount_r[iar_pkg::BufAw-1:0]] <= in_data_byte;
                if (wcount_r == 6'd0) ptr_r <= in_data_byte;
              end
              wcount_r <= wcount_r + 6'd1;
            end
          end
          iar_pkg::CMD_READ_BYTE: begin
            result_r <= (rpos_r < rlen_r && rpos_r < 5'd16) ? resp_r[rpos_r[3:0]] : '0;
            if (rpos_r < 5'd16) rpos_r <= rpos_r + 5'd1;
          end
          default: result_r <= '0;
        endcase
      end
      if (cmd.cipher_start) begin
        // The last right rotation of round 1 leaves the key itself. The counter
        // used is the one bumped by this read start.
        busy_r <= 1'b1; rnd_r <= 1'b1; step_r <= 6'd31;
        s_r <= key_at(1'b1, cnt_r + 8'd1);
      end else if (busy_r) begin
        if (step_r != 6'd0) begin
          if (sel == 3'd0) v_r <= {v_r[31:0], ~v_r[63:32]};
          else if (sel == 3'd1) v_r <= {v_r[31:0], v_r[63:32]} ^ s_r;
          else if (sel == 3'd3) v_r <= {v_r[55:0], v_r[63:56]};
        end
        if (step_r == 6'd1) begin
          if (rnd_r) begin
            rnd_r <= 1'b0; step_r <= 6'd31; s_r <= key_at(1'b0, cnt_r);
          end else begin
            step_r <= 6'd0;
          end
        end else if (step_r == 6'd0) begin
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r - 6'd1;
          s_r <= {s_r[60:0], s_r[63:61]};
        end
      end
      if (cmd.spread) begin
        resp_r[0] <= v_r[63:56]; resp_r[1] <= v_r[55:48];
        resp_r[4] <= v_r[47:40]; resp_r[5] <= v_r[39:32];
        resp_r[8] <= v_r[31:24]; resp_r[9] <= v_r[23:16];
        resp_r[12] <= v_r[15:8]; resp_r[13] <= v_r[7:0];
      end
    end
  end
  assign result = result_r;

  `IAR_ASSERT_NEXT(a_wcount_sat, wcount_r == 6'd63 && !cmd.exec, wcount_r == 6'd63, "count")
  `IAR_ASSERT_IMP(a_rpos_max, 1'b1, rpos_r <= 5'd16, "read position overflow")
  `IAR_ASSERT_IMP(a_start_idle, cmd.cipher_start, !busy_r, "cipher restarted")
endmodule

FILE: design/iar_ctrl.sv
`timescale 1ns / 1ps
`include "i2c_auth_responder_core_defines.svh"
module iar_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  iar_pkg::status_t sts,
  output iar_pkg::cmd_t    cmd
);
  iar_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= iar_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iar_pkg::ST_IDLE: if (in_valid) state_nxt = sts.need_cipher ? iar_pkg::ST_CIPHER
                                                               : iar_pkg::ST_OUT;
      iar_pkg::ST_CIPHER: if (sts.cipher_done) state_nxt = iar_pkg::ST_SPREAD;
      iar_pkg::ST_SPREAD: state_nxt = iar_pkg::ST_OUT;
      iar_pkg::ST_OUT: if (out_ready) state_nxt = iar_pkg::ST_IDLE;
      default: state_nxt = iar_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == iar_pkg::ST_IDLE);
    out_valid = (state_r == iar_pkg::ST_OUT);
    cmd.exec = in_ready && in_valid;
    cmd.cipher_start = in_ready && in_valid && sts.need_cipher;
    cmd.spread = (state_r == iar_pkg::ST_SPREAD);
  end

  `IAR_ASSERT_IMP(a_exclusive, 1'b1, !(in_ready && out_valid), "both sides open")
  `IAR_ASSERT_NEXT(a_spread_out, state_r == iar_pkg::ST_SPREAD,
    state_r == iar_pkg::ST_OUT, "spread not followed by output")
  `IAR_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped")
endmodule

FILE: design/i2c_auth_responder_core.sv
`timescale 1ns / 1ps
// I2C challenge-response target core: one transfer per bus event, one result byte per
// event. Ordinary events execute, then present the result. A read start on a pending
// round runs the inverse cipher sequencer, one step a cycle over both key rounds: 62
// steps, then a closing state with the step counter at zero, then the spread state that
// puts the word into the response, and only then is the result offered.
module i2c_auth_responder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_command,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data
);
  iar_pkg::cmd_t cmd;
  iar_pkg::status_t sts;

  iar_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .cmd);
  iar_datapath u_dp (.clk, .rst_n, .in_command, .in_data_byte, .cmd, .sts,
    .result(out_read_data));
endmodule

FILE: tb/i2c_auth_responder_core_checker.sv
`timescale 1ns / 1ps
module i2c_auth_responder_core_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] in_command,
  input  logic [7:0] in_data_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_read_data,
  output int         fail_count,
  output int         bytes_owed
);
  localparam logic [63:0] ROUND_KEY0 = 64'h9fb7fb2cc0360a1e;
  localparam logic [63:0] ROUND_KEY1 = 64'h09216dba56a09c88;
  localparam int ROT_STEPS = 31;

  logic [7:0]  read_data_q[$];

  logic        in_read;
  logic [7:0]  cmd_buf[iar_pkg::CmdBufferBytes];
  int unsigned cmd_len;
  logic [7:0]  resp_buf[iar_pkg::RespBytes];
  int unsigned resp_count;
  int unsigned read_idx;
  logic [7:0]  auth_ctr;
  logic        pend0, pend1;
  logic [63:0] target0, target1;

  // Runs the target backward through the operations picked by the key schedule.
  function automatic logic [63:0] undo_cipher(logic [63:0] target, logic [7:0] ctr);
    logic [1:0]  kind[2*ROT_STEPS];
    logic [63:0] snap[2*ROT_STEPS];
    logic [63:0] s, v;
    logic [2:0]  sel;
    int          n;
    n = 0;
    v = target;
    for (int rnd = 0; rnd < 2; rnd++) begin
      s = (rnd == 0) ? ROUND_KEY0 : ROUND_KEY1;
      s ^= {24'd0, ctr, 32'd0};
      for (int r = 0; r < ROT_STEPS; r++) s = {s[60:0], s[63:61]};
      for (int r = 0; r < ROT_STEPS; r++) begin
        s = {s[2:0], s[63:3]};
        sel = {s[61], s[63:62]};
        if (sel == 3'd0 || sel == 3'd1 || sel == 3'd3) begin
          kind[n] = sel[1:0];
          snap[n] = s;
          n++;
        end
      end
    end
    while (n > 0) begin
      n--;
      case (kind[n])
        2'd0: v = {v[31:0], ~v[63:32]};
        2'd1: v = {v[31:0], v[63:32]} ^ snap[n];
        default: v = {v[55:0], v[63:56]};
      endcase
    end
    return v;
  endfunction

  function automatic logic [63:0] gather_target();
    logic [63:0] t;
    t = '0;
    for (int i = 0; i < 8; i++) t = {t[55:0], cmd_buf[1 + 2 * i]};
    return t;
  endfunction

  task automatic load_response(logic [63:0] target);
    logic [63:0] w;
    w = undo_cipher(target, auth_ctr);
    for (int i = 0; i < 8; i++) resp_buf[(i / 2) * 4 + (i % 2)] = w[63 - 8 * i -: 8];
  endtask

  task automatic prepare_read();
    logic [7:0] ptr;
    ptr = cmd_buf[0];
    for (int i = 0; i < iar_pkg::RespBytes; i++) resp_buf[i] = 8'd0;
    resp_count = iar_pkg::RespBytes;
    if (ptr == iar_pkg::REG_NONCE) begin
      auth_ctr = 8'd1;
      pend0 = 1'b0;
      pend1 = 1'b0;
    end else if (ptr >= iar_pkg::REG_ZERO_LO && ptr <= iar_pkg::REG_ZERO_HI) begin
      resp_count = 8;
    end else if (ptr == iar_pkg::REG_ROUND0 && pend0) begin
      auth_ctr = auth_ctr + 8'd1;
      load_response(target0);
      pend0 = 1'b0;
    end else if (ptr == iar_pkg::REG_ROUND1 && pend1) begin
      auth_ctr = auth_ctr + 8'd1;
      load_response(target1);
      pend1 = 1'b0;
    end
  endtask

  task automatic finish_write();
    if (cmd_buf[0] == iar_pkg::REG_PHASE3) begin
      auth_ctr = auth_ctr + 8'd2;
    end else if (cmd_buf[0] == iar_pkg::REG_ROUND0 && cmd_len >= 16) begin
      target0 = gather_target();
      pend0 = 1'b1;
    end else if (cmd_buf[0] == iar_pkg::REG_ROUND1 && cmd_len >= 16) begin
      target1 = gather_target();
      pend1 = 1'b1;
    end
  endtask

  task automatic predict_byte(logic [2:0] cmd, logic [7:0] data, output logic [7:0] rd);
    rd = 8'd0;
    case (cmd)
      iar_pkg::CMD_START_WRITE: begin
        in_read = 1'b0;
        cmd_len = 0;
      end
      iar_pkg::CMD_START_READ: begin
        in_read = 1'b1;
        read_idx = 0;
        prepare_read();
      end
      iar_pkg::CMD_FINISH: begin
        if (!in_read && cmd_len > 1) finish_write();
      end
      iar_pkg::CMD_WRITE_BYTE: begin
        if (cmd_len < 63) begin
          if (cmd_len < iar_pkg::CmdBufferBytes) cmd_buf[cmd_len] = data;
          cmd_len++;
        end
      end
      iar_pkg::CMD_READ_BYTE: begin
        if (read_idx < resp_count && read_idx < iar_pkg::RespBytes) rd = resp_buf[read_idx];
        if (read_idx < iar_pkg::RespBytes) read_idx++;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      in_read = 1'b0;
      cmd_len = 0;
      resp_count = 0;
      read_idx = 0;
      auth_ctr = 8'd0;
      pend0 = 1'b0;
      pend1 = 1'b0;
      read_data_q.delete();
      fail_count = 0;
    end else begin
      // Check the result side first: a transfer in this cycle never answers
      // an item accepted in the same cycle.
      if (out_valid && out_ready) begin
        if (read_data_q.size() == 0) begin
          $error("unexpected result: read_data=%0h", out_read_data);
          fail_count++;
        end else begin
          want = read_data_q.pop_front();
          if (out_read_data !== want) begin
            $error("read_data mismatch: expected %0h, actual %0h", want, out_read_data);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_byte(in_command, in_data_byte, want);
        read_data_q.push_back(want);
      end
    end
    bytes_owed = read_data_q.size();
  end
endmodule

FILE: tb/i2c_auth_responder_core_tb.sv
`timescale 1ns / 1ps
module i2c_auth_responder_core_tb;
  localparam logic [2:0] CMD_NACK   = 3'd3;
  localparam logic [2:0] CMD_RSVD6  = 3'd6;
  localparam logic [2:0] CMD_RSVD7  = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 800;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_command = iar_pkg::CMD_START_WRITE;
  logic [7:0] in_data_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  int         fail_count;
  int         bytes_owed;
  int         cycles = 0;
  int         sent = 0;
  logic       no_idle = 1'b0;

  always #5 clk = ~clk;

  i2c_auth_responder_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_read_data(out_read_data)
  );

  i2c_auth_responder_core_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_read_data(out_read_data),
    .fail_count(fail_count), .bytes_owed(bytes_owed)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver stalls a random number of cycles before each transfer, unless no_idle is set.
  initial begin
    int   stall;
    logic seen;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        seen = out_valid;
        @(posedge clk);
      end while (!seen);
    end
  end

  task automatic send(logic [2:0] cmd, logic [7:0] data);
    int   gap;
    logic rdy;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_data_byte <= data;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    sent++;
  endtask

  function automatic logic [7:0] pick_pointer();
    case ($urandom_range(0, 9))
      0, 1: return iar_pkg::REG_ROUND0;
      2, 3: return iar_pkg::REG_ROUND1;
      4:    return iar_pkg::REG_NONCE;
      5:    return iar_pkg::REG_PHASE3;
      6:    return 8'($urandom_range(iar_pkg::REG_ZERO_LO, iar_pkg::REG_ZERO_HI));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_xfer();
    int n;
    case ($urandom_range(0, 5))
      0:       n = $urandom_range(0, 15);
      1:       n = $urandom_range(21, 45);
      default: n = $urandom_range(15, 20);
    endcase
    send(iar_pkg::CMD_START_WRITE, 8'($urandom));
    send(iar_pkg::CMD_WRITE_BYTE, pick_pointer());
    repeat (n) send(iar_pkg::CMD_WRITE_BYTE, 8'($urandom));
    send(iar_pkg::CMD_FINISH, 8'($urandom));
    if ($urandom_range(0, 7) == 0) send(iar_pkg::CMD_FINISH, 8'($urandom));
  endtask

  task automatic read_xfer();
    send(iar_pkg::CMD_START_WRITE, 8'($urandom));
    send(iar_pkg::CMD_WRITE_BYTE, pick_pointer());
    if ($urandom_range(0, 1)) send(iar_pkg::CMD_FINISH, 8'($urandom));
    send(iar_pkg::CMD_START_READ, 8'($urandom));
    repeat ($urandom_range(1, 18)) send(iar_pkg::CMD_READ_BYTE, 8'($urandom));
    send(iar_pkg::CMD_FINISH, 8'($urandom));
  endtask

  task automatic handshake();
    logic [7:0] ptr;
    ptr = $urandom_range(0, 1) ? iar_pkg::REG_ROUND0 : iar_pkg::REG_ROUND1;
    send(iar_pkg::CMD_START_WRITE, 8'($urandom));
    send(iar_pkg::CMD_WRITE_BYTE, ptr);
    repeat (16) send(iar_pkg::CMD_WRITE_BYTE, 8'($urandom));
    send(iar_pkg::CMD_FINISH, 8'($urandom));
    send(iar_pkg::CMD_START_WRITE, 8'($urandom));
    send(iar_pkg::CMD_WRITE_BYTE, ptr);
    send(iar_pkg::CMD_START_READ, 8'($urandom));
    repeat (16) send(iar_pkg::CMD_READ_BYTE, 8'($urandom));
    send(iar_pkg::CMD_FINISH, 8'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nonce read, with reads past the end of the response.
    send(iar_pkg::CMD_START_WRITE, 8'h00);
    send(iar_pkg::CMD_WRITE_BYTE, iar_pkg::REG_NONCE);
    send(iar_pkg::CMD_START_READ, 8'hff);
    repeat (17) send(iar_pkg::CMD_READ_BYTE, 8'hff);
    send(iar_pkg::CMD_FINISH, 8'h00);
    send(CMD_NACK, 8'hff);
    send(CMD_RSVD6, 8'h00);
    send(CMD_RSVD7, 8'hff);
    // A counter bump, finished twice.
    send(iar_pkg::CMD_START_WRITE, 8'h00);
    send(iar_pkg::CMD_WRITE_BYTE, iar_pkg::REG_PHASE3);
    send(iar_pkg::CMD_WRITE_BYTE, 8'hff);
    send(iar_pkg::CMD_FINISH, 8'h00);
    send(iar_pkg::CMD_FINISH, 8'h00);

    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: handshake();
        4, 5:       write_xfer();
        6, 7:       read_xfer();
        default: repeat ($urandom_range(1, 6))
          send(3'($urandom_range(0, 7)), 8'($urandom));
      endcase
      if ($urandom_range(0, 19) == 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
